// ----- rtl/bosi_pkg.sv -----
// Shared types, codes and constants of the bind opcode stream interpreter.
`timescale 1ns / 1ps

package bosi_pkg;

  // Number of segment base registers that exist.
  localparam int SegmentSlots = 4;
  localparam int SegSelW      = (SegmentSlots > 1) ? $clog2(SegmentSlots) : 1;

  // LEB operand accumulation works in groups of seven bits. Group ten means
  // the shift has reached 70 and further bytes are dropped.
  localparam int LebMaxGroups  = 10;
  localparam int LebSignGroups = 4;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_SEG_COUNT      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEG_BASE_FIRST = 3'd1;

  // Bind opcodes (high nibble of an opcode byte).
  localparam logic [3:0] OP_DONE            = 4'h0;
  localparam logic [3:0] OP_SET_ORD_IMM     = 4'h1;
  localparam logic [3:0] OP_SET_ORD_ULEB    = 4'h2;
  localparam logic [3:0] OP_SET_ORD_SPECIAL = 4'h3;
  localparam logic [3:0] OP_SET_SYMBOL      = 4'h4;
  localparam logic [3:0] OP_SET_TYPE        = 4'h5;
  localparam logic [3:0] OP_SET_ADDEND      = 4'h6;
  localparam logic [3:0] OP_SET_SEG_OFFSET  = 4'h7;
  localparam logic [3:0] OP_ADD_ADDR        = 4'h8;
  localparam logic [3:0] OP_BIND            = 4'h9;
  localparam logic [3:0] OP_BIND_ADD_ULEB   = 4'hA;
  localparam logic [3:0] OP_BIND_ADD_IMM    = 4'hB;
  localparam logic [3:0] OP_BIND_ULEB_TIMES = 4'hC;

  localparam logic [7:0] SpecialOrdinalHi = 8'hF0;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_LEB1   = 2'd1,
    PH_LEB2   = 2'd2,
    PH_NAME   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BIND      = 2'd0,
    KIND_NAME_BYTE = 2'd1,
    KIND_NAME_END  = 2'd2,
    KIND_UNKNOWN   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [31:0]        bind_address;
    logic [31:0]        repeat_count;
    logic [32:0]        stride;
    logic [7:0]         name_byte;
    logic [31:0]        lib_ordinal;
    logic [3:0]         bind_type;
    logic signed [31:0] addend;
  } result_t;

  typedef struct packed {
    logic [63:0] accum;
    logic [3:0]  groups;
    logic        more;
    logic [31:0] sleb;
  } leb_t;

endpackage

// ----- rtl/bind_opcode_stream_interpreter_unit.sv -----
// Top level of the bind opcode stream interpreter: parse state and result logic.
`timescale 1ns / 1ps

// The unit reads a dynamic-link bind opcode table one byte per request and
// produces at most one result per byte: a bind (address, repeat count and
// stride), a symbol name byte, a name end, or an unknown-opcode error. It takes
// a new byte in every clock cycle; the result of a byte is registered and shows
// in the cycle after the byte is accepted; the only thing that can hold
// the input back is a full result register whose result the consumer has not
// taken yet. The repeat-bind opcode multiplies its count by its skip in a
// single 32 by 32 multiplier whose product is registered and folded into the
// offset by the next byte, so back-to-back binds still see the right address.
// Segment base registers and the segment count must be written while no
// request is in flight. A byte flagged as the last one of a table returns all
// parse and symbol state to its reset value after it has been handled.
module bind_opcode_stream_interpreter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bosi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bosi_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    table_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [31:0]                   bind_address_o,
  output logic [31:0]                   repeat_count_o,
  output logic [32:0]                   stride_o,
  output logic [7:0]                    name_byte_o,
  output logic [31:0]                   lib_ordinal_o,
  output logic [3:0]                    bind_type_o,
  output logic signed [31:0]            addend_o
);

  // Parse and symbol state.
  bosi_pkg::phase_e   phase_q, phase_d;
  logic [3:0]         pending_q, pending_d;
  logic [63:0]        accum_q, accum_d;
  logic [3:0]         groups_q, groups_d;
  logic [31:0]        first_q, first_d;
  logic [31:0]        ord_q, ord_d;
  logic [3:0]         type_q, type_d;
  logic [3:0]         seg_q, seg_d;
  logic [63:0]        offset_q, offset_d;
  // Offset increment that has not been added yet.
  logic [63:0]        pend_q, pend_d;
  logic signed [31:0] addend_q, addend_d;

  logic               in_fire;
  logic               emit;
  logic               space;
  bosi_pkg::result_t  res;
  bosi_pkg::result_t  res_out;
  bosi_pkg::leb_t     leb;
  logic               seg_valid;
  logic [31:0]        seg_base;
  logic [31:0]        bind_addr;
  logic [63:0]        eff_offset;
  logic [31:0]        leb_lo;
  logic [63:0]        prod;
  logic [32:0]        imm_stride;
  logic [3:0]         op;
  logic [3:0]         imm;

  assign in_ready_o = space;
  assign in_fire    = in_valid_i && in_ready_o;
  assign op         = table_byte_i[7:4];
  assign imm        = table_byte_i[3:0];

  bosi_leb u_leb (
    .accum_i  (accum_q),
    .groups_i (groups_q),
    .byte_i   (table_byte_i),
    .leb_o    (leb)
  );

  bosi_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .seg_i       (seg_q),
    .seg_valid_o (seg_valid),
    .seg_base_o  (seg_base)
  );

  // The offset the current byte sees is the stored offset plus the increment
  // left behind by the previous bind or add.
  assign eff_offset = offset_q + pend_q;
  assign leb_lo     = leb.accum[31:0];
  assign prod       = {32'd0, first_q} * {32'd0, leb_lo};
  assign imm_stride = {27'd0, imm, 2'b00} + 33'd4;
  // A bind into a segment that is not programmed reports address zero.
  assign bind_addr  = seg_valid ? (seg_base + eff_offset[31:0]) : 32'd0;

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    accum_d   = accum_q;
    groups_d  = groups_q;
    first_d   = first_q;
    ord_d     = ord_q;
    type_d    = type_q;
    seg_d     = seg_q;
    offset_d  = eff_offset;
    pend_d    = '0;
    addend_d  = addend_q;
    emit      = 1'b0;

    // Everything but the bind fields reports the state before this byte.
    res.kind         = bosi_pkg::KIND_BIND;
    res.bind_address = '0;
    res.repeat_count = '0;
    res.stride       = '0;
    res.name_byte    = '0;
    res.lib_ordinal  = ord_q;
    res.bind_type    = type_q;
    res.addend       = addend_q;

    case (phase_q)
      bosi_pkg::PH_OPCODE: begin
        unique case (op)
          bosi_pkg::OP_DONE: begin
          end
          bosi_pkg::OP_SET_ORD_IMM: begin
            ord_d = {28'd0, imm};
          end
          bosi_pkg::OP_SET_ORD_SPECIAL: begin
            ord_d = (imm == 4'd0) ? 32'd0 :
                    {24'd0, bosi_pkg::SpecialOrdinalHi | {4'd0, imm}};
          end
          bosi_pkg::OP_SET_SYMBOL: begin
            pending_d = op;
            phase_d   = bosi_pkg::PH_NAME;
          end
          bosi_pkg::OP_SET_TYPE: begin
            type_d = imm;
          end
          bosi_pkg::OP_SET_SEG_OFFSET, bosi_pkg::OP_SET_ORD_ULEB,
          bosi_pkg::OP_SET_ADDEND, bosi_pkg::OP_ADD_ADDR,
          bosi_pkg::OP_BIND_ADD_ULEB, bosi_pkg::OP_BIND_ULEB_TIMES: begin
            if (op == bosi_pkg::OP_SET_SEG_OFFSET) begin
              seg_d = imm;
            end
            pending_d = op;
            phase_d   = bosi_pkg::PH_LEB1;
            accum_d   = '0;
            groups_d  = '0;
          end
          bosi_pkg::OP_BIND: begin
            emit             = 1'b1;
            res.bind_address = bind_addr;
            res.repeat_count = 32'd1;
            res.stride       = 33'd4;
            pend_d           = 64'd4;
          end
          bosi_pkg::OP_BIND_ADD_IMM: begin
            emit             = 1'b1;
            res.bind_address = bind_addr;
            res.repeat_count = 32'd1;
            res.stride       = imm_stride;
            pend_d           = {31'd0, imm_stride};
          end
          default: begin
            emit     = 1'b1;
            res.kind = bosi_pkg::KIND_UNKNOWN;
          end
        endcase
      end

      bosi_pkg::PH_NAME: begin
        emit = 1'b1;
        if (table_byte_i != 8'd0) begin
          res.kind      = bosi_pkg::KIND_NAME_BYTE;
          res.name_byte = table_byte_i;
        end else begin
          res.kind = bosi_pkg::KIND_NAME_END;
          phase_d  = bosi_pkg::PH_OPCODE;
        end
      end

      default: begin
        // One of the two LEB operand phases.
        accum_d  = leb.accum;
        groups_d = leb.groups;
        if (!leb.more) begin
          phase_d = bosi_pkg::PH_OPCODE;
          if (pending_q == bosi_pkg::OP_BIND_ULEB_TIMES) begin
            if (phase_q == bosi_pkg::PH_LEB1) begin
              first_d  = leb_lo;
              phase_d  = bosi_pkg::PH_LEB2;
              accum_d  = '0;
              groups_d = '0;
            end else if (first_q != 32'd0) begin
              // count * (4 + skip) = count * skip + count * 4.
              emit             = 1'b1;
              res.bind_address = bind_addr;
              res.repeat_count = first_q;
              res.stride       = {1'b0, leb_lo} + 33'd4;
              offset_d         = eff_offset + {30'd0, first_q, 2'b00};
              pend_d           = prod;
            end
          end else begin
            unique case (pending_q)
              bosi_pkg::OP_SET_ORD_ULEB: begin
                ord_d = leb_lo;
              end
              bosi_pkg::OP_SET_ADDEND: begin
                addend_d = leb.sleb;
              end
              bosi_pkg::OP_SET_SEG_OFFSET: begin
                offset_d = leb.accum;
              end
              bosi_pkg::OP_ADD_ADDR: begin
                pend_d = leb.accum;
              end
              bosi_pkg::OP_BIND_ADD_ULEB: begin
                emit             = 1'b1;
                res.bind_address = bind_addr;
                res.repeat_count = 32'd1;
                res.stride       = {1'b0, leb_lo} + 33'd4;
                pend_d           = leb.accum + 64'd4;
              end
              default: begin
              end
            endcase
          end
        end
      end
    endcase

    // The last byte of a table returns all parse and symbol state to reset.
    if (last_byte_i) begin
      phase_d   = bosi_pkg::PH_OPCODE;
      pending_d = '0;
      accum_d   = '0;
      groups_d  = '0;
      first_d   = '0;
      ord_d     = '0;
      type_d    = '0;
      seg_d     = '0;
      offset_d  = '0;
      pend_d    = '0;
      addend_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bosi_pkg::PH_OPCODE;
      pending_q <= '0;
      accum_q   <= '0;
      groups_q  <= '0;
      first_q   <= '0;
      ord_q     <= '0;
      type_q    <= '0;
      seg_q     <= '0;
      offset_q  <= '0;
      pend_q    <= '0;
      addend_q  <= '0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      accum_q   <= accum_d;
      groups_q  <= groups_d;
      first_q   <= first_d;
      ord_q     <= ord_d;
      type_q    <= type_d;
      seg_q     <= seg_d;
      offset_q  <= offset_d;
      pend_q    <= pend_d;
      addend_q  <= addend_d;
    end
  end

  bosi_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_fire && emit),
    .result_i (res),
    .space_o  (space),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (res_out)
  );

  assign kind_o         = res_out.kind;
  assign bind_address_o = res_out.bind_address;
  assign repeat_count_o = res_out.repeat_count;
  assign stride_o       = res_out.stride;
  assign name_byte_o    = res_out.name_byte;
  assign lib_ordinal_o  = res_out.lib_ordinal;
  assign bind_type_o    = res_out.bind_type;
  assign addend_o       = res_out.addend;

  // A new result appears only after a request was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result appeared without an accepted request");

  // The last byte of a table leaves the parser clean.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte_i) |=>
      (phase_q == bosi_pkg::PH_OPCODE && offset_q == 64'd0 && pend_q == 64'd0))
    else $error("parse state not cleared after last byte");

  // The LEB group counter saturates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    groups_q <= 4'(bosi_pkg::LebMaxGroups))
    else $error("LEB group counter out of range");

  // Only bind results carry address, count and stride.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != bosi_pkg::KIND_BIND) |->
      (bind_address_o == 32'd0 && repeat_count_o == 32'd0 && stride_o == 33'd0))
    else $error("non-bind result carries bind fields");

  // A bind result always has a nonzero count and at least a stride of four.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == bosi_pkg::KIND_BIND) |->
      (repeat_count_o != 32'd0 && stride_o >= 33'd4))
    else $error("bind result with zero count or short stride");

endmodule

// ----- rtl/bosi_leb.sv -----
// LEB128 operand step: merges one byte into the accumulator and sign-extends.
`timescale 1ns / 1ps

module bosi_leb (
  input  logic [63:0]     accum_i,
  input  logic [3:0]      groups_i,
  input  logic [7:0]      byte_i,
  output bosi_pkg::leb_t  leb_o
);

  logic [63:0] part;
  logic [63:0] accum;
  logic [31:0] sleb;

  always_comb begin
    part = '0;
    for (int g = 0; g < bosi_pkg::LebMaxGroups; g++) begin
      if (groups_i == 4'(g)) begin
        part = {57'd0, byte_i[6:0]} << (7 * g);
      end
    end
    accum = accum_i | part;
  end

  // The sign comes from bit 6 of the final byte and only matters while the
  // top of that byte sits below bit 32.
  always_comb begin
    sleb = accum[31:0];
    for (int g = 0; g < bosi_pkg::LebSignGroups; g++) begin
      if (groups_i == 4'(g) && byte_i[6]) begin
        sleb = sleb | (32'hFFFF_FFFF << (7 * g + 7));
      end
    end
  end

  always_comb begin
    leb_o.accum  = accum;
    leb_o.more   = byte_i[7];
    leb_o.sleb   = sleb;
    leb_o.groups = (byte_i[7] && groups_i < 4'(bosi_pkg::LebMaxGroups)) ?
                   groups_i + 4'd1 : groups_i;
  end

endmodule

// ----- rtl/bosi_cfg.sv -----
// Segment configuration registers and the segment base lookup.
`timescale 1ns / 1ps

module bosi_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bosi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bosi_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [3:0]                     seg_i,
  output logic                           seg_valid_o,
  output logic [31:0]                    seg_base_o
);

  logic [2:0]  seg_count_q;
  logic [31:0] base_q [bosi_pkg::SegmentSlots];
  logic        seg_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= '0;
      for (int i = 0; i < bosi_pkg::SegmentSlots; i++) begin
        base_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bosi_pkg::CFG_SEG_COUNT) begin
        seg_count_q <= cfg_data_i[2:0];
      end else if (cfg_idx_i < bosi_pkg::CFG_SEG_BASE_FIRST +
                   bosi_pkg::CfgIdxW'(bosi_pkg::SegmentSlots)) begin
        base_q[bosi_pkg::SegSelW'(cfg_idx_i - bosi_pkg::CFG_SEG_BASE_FIRST)] <=
          cfg_data_i;
      end
    end
  end

  // A segment is usable only below both the programmed count and the slots.
  assign seg_valid   = (seg_i < {1'b0, seg_count_q}) &&
                       (seg_i < 4'(bosi_pkg::SegmentSlots));
  assign seg_valid_o = seg_valid;
  assign seg_base_o  = seg_valid ? base_q[seg_i[bosi_pkg::SegSelW-1:0]] : '0;

endmodule

// ----- rtl/bosi_out_stage.sv -----
// Result register that holds one result until the consumer takes it.
`timescale 1ns / 1ps

module bosi_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bosi_pkg::result_t result_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output bosi_pkg::result_t result_o
);

  logic              valid_q;
  logic              valid_d;
  bosi_pkg::result_t result_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
